[hw/rtl/stream_key_match_counter_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the key match counter
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_KEY_MATCH_COUNTER_CORE_ASSERT_SVH
`define STREAM_KEY_MATCH_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication
`define SKMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SKMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/skmc_pkg.sv]
// ----------------------------------------------------------------------------
// skmc_pkg
// Shared constants, types and helpers of the key match counter.
// ----------------------------------------------------------------------------
package skmc_pkg;

	localparam int KEY_MAX    = 16;
	localparam int LEN_W      = 5;
	localparam int POS_W      = $clog2(KEY_MAX);
	localparam int CNT_W      = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

	typedef logic [7:0]               byte_t;
	typedef logic [KEY_MAX-1:0][7:0]  key_t;
	typedef logic [POS_W-1:0]         len_m1_t;

	typedef struct packed {
		logic advance;
		logic last;
	} step_ctl_t;

	// Key length minus one, with zero taken as one and large values clamped.
	function automatic len_m1_t len_minus_one(input logic [LEN_W-1:0] len);
		len_m1_t r;
		if (len == '0) begin
			r = '0;
		end else if (len > LEN_W'(KEY_MAX)) begin
			r = POS_W'(KEY_MAX - 1);
		end else begin
			r = POS_W'(len - 1'b1);
		end
		return r;
	endfunction

endpackage

[hw/rtl/skmc_match.sv]
// ----------------------------------------------------------------------------
// skmc_match
// Sliding window of recent text bytes and parallel compare against the key.
// ----------------------------------------------------------------------------
module skmc_match (
	input  logic                clk,
	input  logic                arst_n,
	input  skmc_pkg::step_ctl_t ctl,
	input  skmc_pkg::byte_t     text_byte,
	input  skmc_pkg::key_t      key,
	input  skmc_pkg::len_m1_t   len_m1,
	output logic                window_hit
);
	import skmc_pkg::*;

	byte_t              win_q    [KEY_MAX];
	byte_t              win_next [KEY_MAX];
	logic [KEY_MAX-1:0] byte_ok;

	always_comb begin
		win_next[0] = text_byte;
		for (int i = 1; i < KEY_MAX; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// key byte i lines up with the byte len-1-i positions back
	always_comb begin
		for (int i = 0; i < KEY_MAX; i++) begin
			if (POS_W'(i) > len_m1) begin
				byte_ok[i] = 1'b1;
			end else begin
				byte_ok[i] = (key[i] == win_next[len_m1 - POS_W'(i)]);
			end
		end
	end

	assign window_hit = &byte_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_MAX; i++) win_q[i] <= '0;
		end else if (ctl.advance) begin
			for (int i = 0; i < KEY_MAX; i++) begin
				win_q[i] <= ctl.last ? '0 : win_next[i];
			end
		end
	end

endmodule

[hw/rtl/skmc_tally.sv]
// ----------------------------------------------------------------------------
// skmc_tally
// Position, spacing and count state of one text, plus the result register.
// ----------------------------------------------------------------------------
module skmc_tally (
	input  logic                     clk,
	input  logic                     arst_n,
	input  skmc_pkg::step_ctl_t      ctl,
	input  logic                     window_hit,
	input  skmc_pkg::len_m1_t        len_m1,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic                     found,
	output logic [skmc_pkg::CNT_W-1:0] first_position,
	output logic [skmc_pkg::CNT_W-1:0] match_count
);
	import skmc_pkg::*;

	localparam logic [LEN_W-1:0] SINCE_MAX = LEN_W'(KEY_MAX);
	localparam logic [CNT_W-1:0] SAT       = '1;

	logic [CNT_W-1:0] index_q, index_n;
	logic [LEN_W-1:0] since_q, since_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [CNT_W-1:0] first_q, first_n;
	logic             seen_q, seen_n;
	logic             take;
	logic             out_valid_q;

	always_comb begin
		take = window_hit
			&& (index_q >= CNT_W'(len_m1))
			&& (since_q >= LEN_W'(len_m1));

		seen_n  = seen_q | take;
		first_n = first_q;
		count_n = count_q;
		if (take && !seen_q) begin
			first_n = (index_q != SAT) ? index_q - CNT_W'(len_m1) : SAT;
		end
		if (take && count_q != SAT) begin
			count_n = count_q + 1'b1;
		end

		if (take) begin
			since_n = '0;
		end else if (since_q < SINCE_MAX) begin
			since_n = since_q + 1'b1;
		end else begin
			since_n = since_q;
		end

		index_n = (index_q != SAT) ? index_q + 1'b1 : index_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			since_q <= SINCE_MAX;
			count_q <= '0;
			first_q <= '0;
			seen_q  <= 1'b0;
		end else if (ctl.advance) begin
			if (ctl.last) begin
				index_q <= '0;
				since_q <= SINCE_MAX;
				count_q <= '0;
				first_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				index_q <= index_n;
				since_q <= since_n;
				count_q <= count_n;
				first_q <= first_n;
				seen_q  <= seen_n;
			end
		end
	end

	// result register: the top level only advances a final beat when it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.advance && ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.last) begin
			found          <= seen_n;
			first_position <= seen_n ? first_n : '0;
			match_count    <= count_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/stream_key_match_counter_core.sv]
// ----------------------------------------------------------------------------
// stream_key_match_counter_core
// Counts non-overlapping occurrences of a configured key in a byte stream.
// ----------------------------------------------------------------------------
// Input beats carry one text byte and an end_of_text flag on in_valid/in_ready.
// Each text yields one output beat, on out_valid/out_ready, after its final
// byte: found, the start index of the first match and the match count.
// Pipeline: a byte is registered in the input register on acceptance and is
// evaluated there; a text's result is then held in the result register.
// Throughput: one byte per cycle unless a final byte is held; the window
// compare of all key positions and the count update sit in the evaluation stage.
// When the receiver stalls, non-final bytes keep flowing; a final byte waits
// in the input register until the result register is free.
// The user must write the key registers (cfg_write/cfg_index/cfg_data) only
// while the stream is idle; the block does not enforce this. Reset clears
// the window, the counters and the result valid, sets key length 1, key bytes 0.
// ----------------------------------------------------------------------------
module stream_key_match_counter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [skmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [skmc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          text_byte,
	input  logic                                end_of_text,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic [skmc_pkg::CNT_W-1:0]          first_position,
	output logic [skmc_pkg::CNT_W-1:0]          match_count
);
	import skmc_pkg::*;

	logic [LEN_W-1:0] key_length_q;
	logic [63:0]      key_low_q;
	logic [63:0]      key_high_q;
	key_t             key;
	len_m1_t          len_m1;

	logic             valid_s1;
	byte_t            byte_s1;
	logic             last_s1;
	logic             advance;
	logic             window_hit;
	step_ctl_t        ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= LEN_W'(1);
			key_low_q    <= '0;
			key_high_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_LENGTH: key_length_q <= cfg_data[LEN_W-1:0];
				REG_KEY_LOW:    key_low_q    <= cfg_data;
				REG_KEY_HIGH:   key_high_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign key    = {key_high_q, key_low_q};
	assign len_m1 = len_minus_one(key_length_q);

	// hold a final byte while an undelivered result sits in the output register
	assign advance  = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	assign ctl.advance = advance;
	assign ctl.last    = last_s1;

	skmc_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.text_byte  (byte_s1),
		.key        (key),
		.len_m1     (len_m1),
		.window_hit (window_hit)
	);

	skmc_tally u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.window_hit     (window_hit),
		.len_m1         (len_m1),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.found          (found),
		.first_position (first_position),
		.match_count    (match_count)
	);

	`include "stream_key_match_counter_core_assert.svh"

	`SKMC_ASSERT_NEXT(a_final_held, valid_s1 && last_s1 && out_valid && !out_ready, valid_s1 && last_s1, "final byte dropped while result stalled")
	`SKMC_ASSERT_NOW(a_found_count, out_valid, found == (match_count != '0), "found disagrees with match count")
	`SKMC_ASSERT_NOW(a_pos_clear, out_valid && !found, first_position == '0, "position set without a match")

endmodule
